### hdl/utrb_pkg.sv
`timescale 1ns / 1ps
// Package for the UART transmit ring buffer: payload types, codes, sizes and
// the index advance helper. No dependencies.
package utrb_pkg;

  localparam int RING_DEPTH = 64;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int SIZE_W     = 7;

  localparam logic [1:0] CMD_WRITE    = 2'd0;
  localparam logic [1:0] CMD_SEND     = 2'd1;
  localparam logic [1:0] CMD_COMPLETE = 2'd2;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_BYTE   = 2'd1;
  localparam logic [1:0] KIND_SENT   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_BUSY  = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(RING_DEPTH);

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic       msg_end;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic [1:0] status;
    logic       last;
  } out_t;

  typedef struct packed {
    logic accept;
    logic start_send;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic run_last;
    logic dirty;
    logic busy;
  } dp_stat_t;

  function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] idx,
                                           input logic [SIZE_W-1:0] n);
    logic [SIZE_W-1:0] nx;
    nx = SIZE_W'(idx) + SIZE_W'(1);
    return (nx >= n) ? '0 : nx[IDX_W-1:0];
  endfunction

endpackage

### hdl/uart_tx_ring_buffer_unit.sv
`timescale 1ns / 1ps
// Top level of the UART transmit ring buffer: controller plus datapath.
// Depends on utrb_pkg, utrb_ctrl, utrb_dp (and utrb_ram through it).
//
//   channel | handshake          | payload
//   --------+--------------------+-----------------------------------
//   input   | in_valid/in_ready  | in_data  (cmd, data_byte, msg_end)
//   output  | out_valid/out_ready| out_data (kind, tx_byte, status, last)
//   config  | cfg_we             | cfg_wdata (ring_size)
//
// Write, status and complete commands each load their result into the output
// register, where it sits while the next command is taken.
// A send that runs first starts the store read, then emits one byte per cycle
// while the output is free; the registered store read port sets that pace.
// Reset clears the head and tail indices, flags and the output valid; ring_size returns to 64.
// A stalled output holds the run; no input is taken during a send run.
module uart_tx_ring_buffer_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  utrb_pkg::in_t               in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output utrb_pkg::out_t              out_data,
  input  logic                        cfg_we,
  input  logic [utrb_pkg::SIZE_W-1:0] cfg_wdata
);
  import utrb_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  utrb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  utrb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### hdl/utrb_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module utrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/utrb_ctrl.sv
`timescale 1ns / 1ps
// Controller for the UART transmit ring buffer: idle / send-run state machine.
// Depends on utrb_pkg.
module utrb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          in_cmd,
  output logic                in_ready,
  input  utrb_pkg::dp_stat_t  stat,
  output utrb_pkg::ctrl_cmd_t cmd
);
  import utrb_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EMIT = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd.accept     = 1'b0;
    cmd.start_send = 1'b0;
    cmd.emit       = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready   = stat.out_free;
        cmd.accept = in_valid && stat.out_free;
        if (cmd.accept && in_cmd == CMD_SEND && stat.dirty && !stat.busy) begin
          cmd.start_send = 1'b1;
          state_next     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.run_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_no_accept_in_run: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> !in_ready) else $error("input taken during send run");

  a_start_enters_run: assert property (@(posedge clk) disable iff (rst)
    cmd.start_send |=> state == S_EMIT) else $error("send start did not enter run");

endmodule

### hdl/utrb_dp.sv
`timescale 1ns / 1ps
// Datapath for the UART transmit ring buffer: byte store, indices, flags,
// size register and output register. Depends on utrb_pkg and utrb_ram.
module utrb_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  utrb_pkg::in_t              in_data,
  input  utrb_pkg::ctrl_cmd_t        cmd,
  output utrb_pkg::dp_stat_t         stat,
  input  logic                       cfg_we,
  input  logic [utrb_pkg::SIZE_W-1:0] cfg_wdata,
  output logic                       out_valid,
  input  logic                       out_ready,
  output utrb_pkg::out_t             out_data
);
  import utrb_pkg::*;

  logic [SIZE_W-1:0] ring_size;
  logic [SIZE_W-1:0] eff_n;
  logic [IDX_W-1:0]  head;
  logic [IDX_W-1:0]  tail;
  logic              dirty;
  logic              busy;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  idx_next;
  logic [SIZE_W-1:0] cnt;
  logic [SIZE_W-1:0] cnt_next;
  logic              single;
  logic              load;
  logic              ram_we;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [7:0]        ram_rdata;
  out_t              res;

  always_comb begin
    if (ring_size == '0) begin
      eff_n = SIZE_W'(1);
    end else if (ring_size > SIZE_W'(RING_DEPTH)) begin
      eff_n = SIZE_W'(RING_DEPTH);
    end else begin
      eff_n = ring_size;
    end
  end

  assign idx_next = adv(rd_idx, eff_n);
  assign cnt_next = cnt + SIZE_W'(1);

  assign stat.out_free = !out_valid || out_ready;
  assign stat.run_last = (idx_next == head) || (cnt_next >= eff_n);
  assign stat.dirty    = dirty;
  assign stat.busy     = busy;

  assign single = cmd.accept && !cmd.start_send;
  assign load   = single || cmd.emit;
  assign ram_we = single && in_data.cmd == CMD_WRITE;
  assign ram_re = cmd.start_send || (cmd.emit && !stat.run_last);
  assign ram_raddr = cmd.start_send ? tail : idx_next;

  utrb_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head),
    .wdata (in_data.data_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    res.kind    = KIND_STATUS;
    res.tx_byte = 8'd0;
    res.status  = ST_OK;
    res.last    = 1'b1;
    if (cmd.emit) begin
      res.kind    = KIND_BYTE;
      res.tx_byte = ram_rdata;
      res.last    = stat.run_last;
    end else begin
      case (in_data.cmd)
        CMD_SEND:     res.status = dirty ? ST_BUSY : ST_EMPTY;
        CMD_COMPLETE: res.kind   = KIND_SENT;
        default:      res.status = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size <= SIZE_RESET;
      head      <= '0;
      tail      <= '0;
      dirty     <= 1'b0;
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        ring_size <= cfg_wdata;
      end
      if (ram_we) begin
        head  <= adv(head, eff_n);
        dirty <= 1'b1;
      end
      if (single && in_data.cmd == CMD_COMPLETE) begin
        busy <= 1'b0;
      end
      if (cmd.start_send) begin
        tail  <= head;
        dirty <= 1'b0;
        busy  <= 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_send) begin
      rd_idx <= tail;
      cnt    <= '0;
    end else if (cmd.emit) begin
      rd_idx <= idx_next;
      cnt    <= cnt_next;
    end
    if (load) begin
      out_data <= res;
    end
  end

  a_emit_into_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free) else $error("emit into occupied output");

  a_run_bounded: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> cnt < eff_n) else $error("send run exceeded ring size");

  a_start_flags: assert property (@(posedge clk) disable iff (rst)
    cmd.start_send |=> busy && !dirty) else $error("flags wrong after send start");

endmodule

### verif/uart_tx_ring_buffer_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for uart_tx_ring_buffer_unit: bursty driver, stalling sink,
// in-bench ring model predicting every result. Depends on utrb_pkg and the RTL.
module uart_tx_ring_buffer_unit_tb;
  import utrb_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int ITEMS_PER_PHASE = 36;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata = '0;

  uart_tx_ring_buffer_unit u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ring model
  logic [7:0] ring_mem [RING_DEPTH];
  logic [IDX_W-1:0] wr_ptr = '0;
  logic [IDX_W-1:0] rd_ptr = '0;
  logic has_unsent = 1'b0;
  logic xfer_busy = 1'b0;
  logic [SIZE_W-1:0] ring_cfg = SIZE_RESET;

  out_t results_due [$];
  in_t pending_items [$];
  int items_queued = 0;
  int items_accepted = 0;
  int results_seen = 0;
  int err_count = 0;
  int idle_cycles = 0;
  logic in_took = 1'b0;

  int burst_left = 0;
  int gap_left = 0;
  int stall_left = 0;
  int rx_mode = 0;
  int rx_tick = 0;

  function automatic int unsigned span_of(input logic [SIZE_W-1:0] v);
    if (v < 1) return 1;
    if (v > RING_DEPTH) return RING_DEPTH;
    return 32'(v);
  endfunction

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] p,
                                                 input int unsigned span);
    return (int'(p) + 1 >= span) ? '0 : p + 1'b1;
  endfunction

  function automatic out_t mk_result(input logic [1:0] kind, input logic [7:0] b,
                                     input logic [1:0] st, input logic last);
    out_t r;
    r.kind = kind;
    r.tx_byte = b;
    r.status = st;
    r.last = last;
    return r;
  endfunction

  task automatic ring_apply(input in_t item);
    int unsigned span;
    int unsigned cnt;
    logic [IDX_W-1:0] idx;
    logic done;
    span = span_of(ring_cfg);
    case (item.cmd)
      CMD_WRITE: begin
        ring_mem[wr_ptr] = item.data_byte;
        wr_ptr = ring_next(wr_ptr, span);
        has_unsent = 1'b1;
        results_due.push_back(mk_result(KIND_STATUS, 8'd0, ST_OK, 1'b1));
      end
      CMD_SEND: begin
        if (!has_unsent) begin
          results_due.push_back(mk_result(KIND_STATUS, 8'd0, ST_EMPTY, 1'b1));
        end else if (xfer_busy) begin
          results_due.push_back(mk_result(KIND_STATUS, 8'd0, ST_BUSY, 1'b1));
        end else begin
          idx = rd_ptr;
          cnt = 0;
          done = 1'b0;
          while (!done) begin
            cnt++;
            done = (ring_next(idx, span) == wr_ptr) || (cnt >= span);
            results_due.push_back(mk_result(KIND_BYTE, ring_mem[idx], ST_OK, done));
            idx = ring_next(idx, span);
          end
          rd_ptr = wr_ptr;
          has_unsent = 1'b0;
          xfer_busy = 1'b1;
        end
      end
      CMD_COMPLETE: begin
        xfer_busy = 1'b0;
        results_due.push_back(mk_result(KIND_SENT, 8'd0, ST_OK, 1'b1));
      end
      default: begin
        results_due.push_back(mk_result(KIND_STATUS, 8'd0, ST_OK, 1'b1));
      end
    endcase
  endtask

  task automatic note_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want)
      note_error($sformatf("result %0d field %s got %0h, expected %0h",
                           results_seen, name, got, want));
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    results_seen++;
    if (results_due.size() == 0) begin
      note_error($sformatf("result %0d arrived with nothing outstanding", results_seen));
    end else begin
      want = results_due.pop_front();
      compare_field("kind", 8'(got.kind), 8'(want.kind));
      compare_field("tx_byte", got.tx_byte, want.tx_byte);
      compare_field("status", 8'(got.status), 8'(want.status));
      compare_field("last", 8'(got.last), 8'(want.last));
    end
  endtask

  // monitor and watchdog
  always @(posedge clk) begin : monitor
    logic in_fire;
    logic out_fire;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      out_fire = out_valid && out_ready;
      in_fire = in_valid && in_ready;
      if (out_fire) check_result(out_data);
      if (in_fire) begin
        ring_apply(in_data);
        items_accepted++;
        in_took = 1'b1;
      end
      if (in_fire || out_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // input driver: bursts with random gaps
  always @(negedge clk) begin : driver
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      in_took = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output sink: stall pattern periodically switches to a randomly chosen mode
  always @(negedge clk) begin : sink
    logic rdy;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      rdy = 1'b1;
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        case (rx_mode)
          1: rdy = ($urandom_range(0, 3) != 0);
          2: rdy = (rx_tick[1:0] != 2'b11);
          3: if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(4, 20);
          default: rdy = 1'b1;
        endcase
      end
      rx_tick++;
      if (rx_tick % 97 == 0) rx_mode = $urandom_range(0, 3);
      out_ready <= rdy;
    end
  end

  task automatic queue_cmd(input logic [1:0] cmd, input logic [7:0] b, input logic e);
    in_t item;
    item.cmd = cmd;
    item.data_byte = b;
    item.msg_end = e;
    pending_items.push_back(item);
    items_queued++;
  endtask

  task automatic wait_idle;
    @(negedge clk);
    while (items_accepted != items_queued || results_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_ring_size(input logic [SIZE_W-1:0] v);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    ring_cfg = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly write/send/complete messages, the rest stray commands
  task automatic queue_traffic(input int count, input int unsigned span);
    int queued;
    int len;
    queued = 0;
    while (queued < count) begin
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 5) == 0) len = $urandom_range(1, span + 2);
        else len = $urandom_range(1, (span < 8) ? span + 1 : 8);
        for (int i = 0; i < len; i++)
          queue_cmd(CMD_WRITE, 8'($urandom_range(0, 255)), i == len - 1);
        queue_cmd(CMD_SEND, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 3) == 0)
          queue_cmd(CMD_SEND, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        queue_cmd(CMD_COMPLETE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        queued += len + 2;
      end else begin
        queue_cmd(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
        queued++;
      end
    end
  endtask

  initial begin : stimulus
    logic [SIZE_W-1:0] sizes [10];
    sizes = '{7'd1, 7'd0, 7'd127, 7'd5, 7'd64, 7'd2, 7'd65, 7'd63, 7'd16, 7'd40};
    sizes[9] = SIZE_W'($urandom_range(1, RING_DEPTH));
    for (int i = 0; i < RING_DEPTH; i++) ring_mem[i] = 8'd0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // fill every entry, then send the full ring
    for (int i = 0; i < RING_DEPTH; i++)
      queue_cmd(CMD_WRITE, 8'($urandom_range(0, 255)), i == RING_DEPTH - 1);
    queue_cmd(CMD_SEND, 8'h00, 1'b0);
    queue_cmd(CMD_COMPLETE, 8'h00, 1'b0);

    queue_cmd(CMD_SEND, 8'hFF, 1'b1);
    queue_cmd(CMD_WRITE, 8'h00, 1'b0);
    queue_cmd(CMD_WRITE, 8'hFF, 1'b1);
    queue_cmd(CMD_SEND, 8'h00, 1'b0);
    queue_cmd(CMD_WRITE, 8'h5A, 1'b1);
    queue_cmd(CMD_SEND, 8'hFF, 1'b0);
    queue_cmd(CMD_COMPLETE, 8'hFF, 1'b1);
    queue_cmd(CMD_COMPLETE, 8'h00, 1'b0);
    queue_cmd(CMD_SEND, 8'hA5, 1'b1);
    queue_cmd(CMD_UNUSED, 8'hFF, 1'b1);
    queue_cmd(CMD_UNUSED, 8'h00, 1'b0);
    queue_cmd(CMD_SEND, 8'h5A, 1'b0);
    queue_cmd(CMD_COMPLETE, 8'h00, 1'b0);
    queue_cmd(CMD_SEND, 8'hA5, 1'b1);
    queue_cmd(CMD_COMPLETE, 8'hFF, 1'b1);

    foreach (sizes[p]) begin
      wait_idle();
      write_ring_size(sizes[p]);
      queue_traffic(ITEMS_PER_PHASE, span_of(sizes[p]));
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (err_count == 0 && results_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
